/* sv/flra_pkg.sv */
// ----------------------------------------------------------------------------
// flra_pkg
// Shared constants, request and response types for the region allocator.
// ----------------------------------------------------------------------------
package flra_pkg;

    localparam int HEAP_BYTES    = 4096;
    localparam int TABLE_ENTRIES = 64;
    localparam int ADDR_W        = 12;
    localparam int SIZE_W        = 13;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int MODE_W        = 3;
    localparam int ENT_W         = SIZE_W + ADDR_W;

    // request kinds
    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_FREE   = 2'd1;
    localparam logic [1:0] KIND_RESIZE = 2'd2;

    // response status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_NOT_FND  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // fit modes
    localparam logic [MODE_W-1:0] FIT_EXACT       = 3'd0;
    localparam logic [MODE_W-1:0] FIT_BEST        = 3'd1;
    localparam logic [MODE_W-1:0] FIT_LOWEST      = 3'd2;
    localparam logic [MODE_W-1:0] FIT_EXACT_BEST  = 3'd3;
    localparam logic [MODE_W-1:0] FIT_EXACT_FIRST = 3'd4;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] req_size;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] region_start;
        logic [SIZE_W-1:0] region_size;
    } t_rsp;

    // one table entry
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] start;
    } t_ent;

endpackage

/* sv/flra_ram.sv */
// ----------------------------------------------------------------------------
// flra_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module flra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/free_list_region_allocator_core.sv */
// ----------------------------------------------------------------------------
// free_list_region_allocator_core
// Heap region allocator with sorted used and free tables and hole merging.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_in_valid / o_in_stall carries kind, address, req_size.
//   A request is taken when valid is high and stall low; stall is high while
//   a request is being worked on. Each request gives exactly one response on
//   o_out_valid / i_out_stall (status, region_start, region_size).
//   fit_mode is written through i_cfg_valid / o_cfg_ready / i_cfg_data;
//   the user must write it only while the block is idle, which the block
//   itself does not enforce; ready is always high. A sequencer walks the
//   two table RAMs one entry at a time, with a read step and then an
//   evaluate or write step, through a lookup pass, a release pass with
//   its shift, and an allocate scan plus an insertion shift. Each table
//   RAM has a single read port and a single write port.
//   The response sits in an output register; a new request is taken while
//   it waits, and the block holds its next response until the register is
//   free when the receiver stalls.
//   Reset clears the counts, the heap top and fit_mode; table contents need
//   no clearing, as only entries below the counts are read.
// ----------------------------------------------------------------------------
module free_list_region_allocator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  flra_pkg::t_req                       i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output flra_pkg::t_rsp                       o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [flra_pkg::MODE_W-1:0]          i_cfg_data
);

    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_LK_RD  = 20'h00002,
        S_LK_EV  = 20'h00004,
        S_RL_RD  = 20'h00008,
        S_RL_EV  = 20'h00010,
        S_RL_DEC = 20'h00020,
        S_FIN_RD = 20'h00040,
        S_FIN_WR = 20'h00080,
        S_FRM_RD = 20'h00100,
        S_FRM_WR = 20'h00200,
        S_REL_OK = 20'h00400,
        S_URM_RD = 20'h00800,
        S_URM_WR = 20'h01000,
        S_AL_ST  = 20'h02000,
        S_AL_RD  = 20'h04000,
        S_AL_EV  = 20'h08000,
        S_AL_DEC = 20'h10000,
        S_UIN_RD = 20'h20000,
        S_UIN_EV = 20'h40000,
        S_DONE   = 20'h80000
    } t_state;

    localparam int AW = flra_pkg::ADDR_W;
    localparam int SW = flra_pkg::SIZE_W;
    localparam int IW = flra_pkg::IDX_W;
    localparam int CW = flra_pkg::CNT_W;

    t_state r_state, n_state;

    // control state
    logic [flra_pkg::MODE_W-1:0] r_mode;
    logic [CW-1:0] r_uc, n_uc, r_fc, n_fc;
    logic [SW-1:0] r_top, n_top;
    logic          r_ov;
    logic          r_in_alloc, n_in_alloc;

    // request and working registers
    logic [1:0]    r_kind, n_kind;
    logic [AW-1:0] r_addr, n_addr;
    logic [SW-1:0] r_n, n_n;
    logic [CW-1:0] r_j, n_j, r_p, n_p;
    logic [IW-1:0] r_ui, n_ui;
    flra_pkg::t_ent r_ue, n_ue;     // looked-up used entry
    flra_pkg::t_ent r_rel, n_rel;   // region being released
    flra_pkg::t_ent r_prv, n_prv;   // hole before release point
    logic           r_prv_v, n_prv_v;
    flra_pkg::t_ent r_cur, n_cur;   // hole after release point
    logic           r_cur_v, n_cur_v;
    flra_pkg::t_ent r_new, n_new;   // entry to insert in used table
    logic           r_ex_v, n_ex_v, r_fi_v, n_fi_v, r_be_v, n_be_v;
    logic [IW-1:0]  r_ex_i, n_ex_i, r_fi_i, n_fi_i, r_be_i, n_be_i;
    flra_pkg::t_ent r_ex, n_ex, r_fi, n_fi, r_be, n_be;
    flra_pkg::t_rsp r_res, n_res, r_out;

    // table RAM ports
    logic           u_we, f_we;
    logic [IW-1:0]  u_waddr, f_waddr, u_raddr, f_raddr;
    flra_pkg::t_ent u_wdata, f_wdata, u_rd, f_rd;
    logic [flra_pkg::ENT_W-1:0] u_rdata, f_rdata;

    assign u_rd = u_rdata;
    assign f_rd = f_rdata;

    flra_ram #(.WIDTH(flra_pkg::ENT_W), .DEPTH(flra_pkg::TABLE_ENTRIES)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_raddr (u_raddr),
        .o_rdata (u_rdata)
    );

    flra_ram #(.WIDTH(flra_pkg::ENT_W), .DEPTH(flra_pkg::TABLE_ENTRIES)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    // handshakes
    logic w_in_acc, w_out_load;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_load  = (r_state == S_DONE) && (!r_ov || !i_out_stall);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // helper values
    logic [CW-1:0] w_j_p1, w_j_m1, w_p_m1;
    logic [SW-1:0] w_prv_end, w_rel_end;
    logic          w_pre, w_aft, w_hit, w_full_u, w_full_f;
    logic [IW-1:0] w_h_i;
    flra_pkg::t_ent w_h;
    logic [SW:0]   w_room;

    assign w_j_p1    = r_j + CW'(1);
    assign w_j_m1    = r_j - CW'(1);
    assign w_p_m1    = r_p - CW'(1);
    assign w_prv_end = SW'(r_prv.start) + r_prv.size;
    assign w_rel_end = SW'(r_rel.start) + r_rel.size;
    assign w_pre     = r_prv_v && (w_prv_end == SW'(r_rel.start));
    assign w_aft     = r_cur_v && (w_rel_end == SW'(r_cur.start));
    assign w_full_u  = (r_uc == CW'(flra_pkg::TABLE_ENTRIES));
    assign w_full_f  = (r_fc == CW'(flra_pkg::TABLE_ENTRIES));
    assign w_room    = (SW+1)'(flra_pkg::HEAP_BYTES) - (SW+1)'(r_top);

    // hole choice by fit mode
    always_comb begin
        w_hit = 1'b0;
        w_h_i = r_ex_i;
        w_h   = r_ex;
        unique case (r_mode)
            flra_pkg::FIT_EXACT: begin
                w_hit = r_ex_v;
            end
            flra_pkg::FIT_BEST: begin
                w_hit = r_be_v; w_h_i = r_be_i; w_h = r_be;
            end
            flra_pkg::FIT_LOWEST: begin
                w_hit = r_fi_v; w_h_i = r_fi_i; w_h = r_fi;
            end
            flra_pkg::FIT_EXACT_BEST: begin
                if (r_ex_v) begin
                    w_hit = 1'b1;
                end else begin
                    w_hit = r_be_v; w_h_i = r_be_i; w_h = r_be;
                end
            end
            flra_pkg::FIT_EXACT_FIRST: begin
                if (r_ex_v) begin
                    w_hit = 1'b1;
                end else begin
                    w_hit = r_fi_v; w_h_i = r_fi_i; w_h = r_fi;
                end
            end
            default: begin
                w_hit = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_uc       = r_uc;
        n_fc       = r_fc;
        n_top      = r_top;
        n_in_alloc = r_in_alloc;
        n_kind     = r_kind;
        n_addr     = r_addr;
        n_n        = r_n;
        n_j        = r_j;
        n_p        = r_p;
        n_ui       = r_ui;
        n_ue       = r_ue;
        n_rel      = r_rel;
        n_prv      = r_prv;
        n_prv_v    = r_prv_v;
        n_cur      = r_cur;
        n_cur_v    = r_cur_v;
        n_new      = r_new;
        n_ex_v     = r_ex_v;
        n_fi_v     = r_fi_v;
        n_be_v     = r_be_v;
        n_ex_i     = r_ex_i;
        n_fi_i     = r_fi_i;
        n_be_i     = r_be_i;
        n_ex       = r_ex;
        n_fi       = r_fi;
        n_be       = r_be;
        n_res      = r_res;
        u_we       = 1'b0;
        f_we       = 1'b0;
        u_waddr    = r_j[IW-1:0];
        f_waddr    = r_j[IW-1:0];
        u_wdata    = u_rd;
        f_wdata    = f_rd;
        u_raddr    = r_j[IW-1:0];
        f_raddr    = r_j[IW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_kind = i_in_data.kind;
                    n_addr = i_in_data.address;
                    n_n    = i_in_data.req_size;
                    n_j    = '0;
                    if (i_in_data.kind == flra_pkg::KIND_ALLOC) begin
                        n_state = S_AL_ST;
                    end else if (i_in_data.kind == flra_pkg::KIND_FREE ||
                                 i_in_data.kind == flra_pkg::KIND_RESIZE) begin
                        n_state = S_LK_RD;
                    end else begin
                        n_res   = '{flra_pkg::ST_NOT_FND, '0, '0};
                        n_state = S_DONE;
                    end
                end
            end

            // look up the used region by start
            S_LK_RD: begin
                if (r_j < r_uc) begin
                    n_state = S_LK_EV;
                end else begin
                    n_res   = '{flra_pkg::ST_NOT_FND, r_addr, '0};
                    n_state = S_DONE;
                end
            end
            S_LK_EV: begin
                if (u_rd.start == r_addr) begin
                    n_ui      = r_j[IW-1:0];
                    n_ue      = u_rd;
                    n_rel     = u_rd;
                    n_j       = '0;
                    n_prv_v   = 1'b0;
                    n_in_alloc = 1'b0;
                    n_state   = S_RL_RD;
                    if (r_kind == flra_pkg::KIND_RESIZE) begin
                        if (r_n == '0) begin
                            n_res   = '{flra_pkg::ST_NO_SPACE, '0, '0};
                            n_state = S_DONE;
                        end else if (r_n < u_rd.size) begin
                            n_rel.size  = u_rd.size - r_n;
                            n_rel.start = u_rd.start + AW'(r_n);
                        end else if (r_n == u_rd.size) begin
                            n_res   = '{flra_pkg::ST_OK, u_rd.start, r_n};
                            n_state = S_DONE;
                        end
                    end
                end else begin
                    n_j     = w_j_p1;
                    n_state = S_LK_RD;
                end
            end

            // find where the released region goes in the free table
            S_RL_RD: begin
                if (r_j < r_fc) begin
                    n_state = S_RL_EV;
                end else begin
                    n_p     = r_j;
                    n_cur_v = 1'b0;
                    n_state = S_RL_DEC;
                end
            end
            S_RL_EV: begin
                if (f_rd.start <= r_rel.start) begin
                    n_prv   = f_rd;
                    n_prv_v = 1'b1;
                    n_j     = w_j_p1;
                    n_state = S_RL_RD;
                end else begin
                    n_p     = r_j;
                    n_cur   = f_rd;
                    n_cur_v = 1'b1;
                    n_state = S_RL_DEC;
                end
            end
            S_RL_DEC: begin
                if (w_pre && w_aft) begin
                    f_we    = 1'b1;
                    f_waddr = w_p_m1[IW-1:0];
                    f_wdata = '{r_prv.size + r_rel.size + r_cur.size, r_prv.start};
                    n_j     = r_p;
                    n_state = S_FRM_RD;
                end else if (w_pre) begin
                    f_we    = 1'b1;
                    f_waddr = w_p_m1[IW-1:0];
                    f_wdata = '{r_prv.size + r_rel.size, r_prv.start};
                    n_state = S_REL_OK;
                end else if (w_aft) begin
                    f_we    = 1'b1;
                    f_waddr = r_p[IW-1:0];
                    f_wdata = '{r_cur.size + r_rel.size, r_rel.start};
                    n_state = S_REL_OK;
                end else if (w_full_f) begin
                    n_res   = '{flra_pkg::ST_FULL, '0, '0};
                    n_state = S_DONE;
                end else begin
                    n_j     = r_fc;
                    n_state = S_FIN_RD;
                end
            end

            // open a slot in the free table and insert the new hole
            S_FIN_RD: begin
                if (r_j == r_p) begin
                    f_we    = 1'b1;
                    f_waddr = r_p[IW-1:0];
                    f_wdata = r_rel;
                    n_fc    = r_fc + CW'(1);
                    n_state = S_REL_OK;
                end else begin
                    f_raddr = w_j_m1[IW-1:0];
                    n_state = S_FIN_WR;
                end
            end
            S_FIN_WR: begin
                f_we    = 1'b1;
                n_j     = w_j_m1;
                n_state = S_FIN_RD;
            end

            // close a gap in the free table
            S_FRM_RD: begin
                if (w_j_p1 < r_fc) begin
                    f_raddr = w_j_p1[IW-1:0];
                    n_state = S_FRM_WR;
                end else begin
                    n_fc = r_fc - CW'(1);
                    if (r_in_alloc) begin
                        n_j     = r_uc;
                        n_state = S_UIN_RD;
                    end else begin
                        n_state = S_REL_OK;
                    end
                end
            end
            S_FRM_WR: begin
                f_we    = 1'b1;
                n_j     = w_j_p1;
                n_state = S_FRM_RD;
            end

            // release done: finish free or resize
            S_REL_OK: begin
                if (r_kind == flra_pkg::KIND_RESIZE && r_n < r_ue.size) begin
                    u_we    = 1'b1;
                    u_waddr = r_ui;
                    u_wdata = '{r_n, r_ue.start};
                    n_res   = '{flra_pkg::ST_OK, r_ue.start, r_n};
                    n_state = S_DONE;
                end else begin
                    n_j     = CW'(r_ui);
                    n_state = S_URM_RD;
                end
            end

            // close a gap in the used table
            S_URM_RD: begin
                if (w_j_p1 < r_uc) begin
                    u_raddr = w_j_p1[IW-1:0];
                    n_state = S_URM_WR;
                end else begin
                    n_uc = r_uc - CW'(1);
                    if (r_kind == flra_pkg::KIND_FREE) begin
                        n_res   = '{flra_pkg::ST_OK, r_ue.start, r_ue.size};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_AL_ST;
                    end
                end
            end
            S_URM_WR: begin
                u_we    = 1'b1;
                n_j     = w_j_p1;
                n_state = S_URM_RD;
            end

            // allocate: scan holes for exact, first and best candidates
            S_AL_ST: begin
                if (r_n == '0) begin
                    n_res   = '{flra_pkg::ST_NO_SPACE, '0, '0};
                    n_state = S_DONE;
                end else begin
                    n_ex_v  = 1'b0;
                    n_fi_v  = 1'b0;
                    n_be_v  = 1'b0;
                    n_j     = '0;
                    n_state = S_AL_RD;
                end
            end
            S_AL_RD: begin
                if (r_j < r_fc) begin
                    n_state = S_AL_EV;
                end else begin
                    n_state = S_AL_DEC;
                end
            end
            S_AL_EV: begin
                if (f_rd.size == r_n && !r_ex_v) begin
                    n_ex_v = 1'b1;
                    n_ex_i = r_j[IW-1:0];
                    n_ex   = f_rd;
                end
                if (f_rd.size >= r_n && !r_fi_v) begin
                    n_fi_v = 1'b1;
                    n_fi_i = r_j[IW-1:0];
                    n_fi   = f_rd;
                end
                if (f_rd.size >= r_n && (!r_be_v || f_rd.size < r_be.size)) begin
                    n_be_v = 1'b1;
                    n_be_i = r_j[IW-1:0];
                    n_be   = f_rd;
                end
                n_j     = w_j_p1;
                n_state = S_AL_RD;
            end
            S_AL_DEC: begin
                if (w_hit) begin
                    if (w_full_u) begin
                        n_res   = '{flra_pkg::ST_FULL, '0, '0};
                        n_state = S_DONE;
                    end else begin
                        n_new = '{r_n, w_h.start};
                        if (w_h.size == r_n) begin
                            n_j        = CW'(w_h_i);
                            n_in_alloc = 1'b1;
                            n_state    = S_FRM_RD;
                        end else begin
                            f_we    = 1'b1;
                            f_waddr = w_h_i;
                            f_wdata = '{w_h.size - r_n, w_h.start + AW'(r_n)};
                            n_j     = r_uc;
                            n_state = S_UIN_RD;
                        end
                    end
                end else if ((SW+1)'(r_n) > w_room) begin
                    n_res   = '{flra_pkg::ST_NO_SPACE, '0, '0};
                    n_state = S_DONE;
                end else if (w_full_u) begin
                    n_res   = '{flra_pkg::ST_FULL, '0, '0};
                    n_state = S_DONE;
                end else begin
                    n_new   = '{r_n, r_top[AW-1:0]};
                    n_top   = r_top + r_n;
                    n_j     = r_uc;
                    n_state = S_UIN_RD;
                end
            end

            // sorted insert into the used table
            S_UIN_RD: begin
                if (r_j == '0) begin
                    u_we    = 1'b1;
                    u_waddr = '0;
                    u_wdata = r_new;
                    n_uc    = r_uc + CW'(1);
                    n_res   = '{flra_pkg::ST_OK, r_new.start, r_new.size};
                    n_state = S_DONE;
                end else begin
                    u_raddr = w_j_m1[IW-1:0];
                    n_state = S_UIN_EV;
                end
            end
            S_UIN_EV: begin
                u_we = 1'b1;
                if (u_rd.start > r_new.start) begin
                    n_j     = w_j_m1;
                    n_state = S_UIN_RD;
                end else begin
                    u_wdata = r_new;
                    n_uc    = r_uc + CW'(1);
                    n_res   = '{flra_pkg::ST_OK, r_new.start, r_new.size};
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_uc       <= '0;
            r_fc       <= '0;
            r_top      <= '0;
            r_mode     <= flra_pkg::FIT_EXACT;
            r_ov       <= 1'b0;
            r_in_alloc <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_uc       <= n_uc;
            r_fc       <= n_fc;
            r_top      <= n_top;
            r_in_alloc <= n_in_alloc;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_addr  <= n_addr;
        r_n     <= n_n;
        r_j     <= n_j;
        r_p     <= n_p;
        r_ui    <= n_ui;
        r_ue    <= n_ue;
        r_rel   <= n_rel;
        r_prv   <= n_prv;
        r_prv_v <= n_prv_v;
        r_cur   <= n_cur;
        r_cur_v <= n_cur_v;
        r_new   <= n_new;
        r_ex_v  <= n_ex_v;
        r_fi_v  <= n_fi_v;
        r_be_v  <= n_be_v;
        r_ex_i  <= n_ex_i;
        r_fi_i  <= n_fi_i;
        r_be_i  <= n_be_i;
        r_ex    <= n_ex;
        r_fi    <= n_fi;
        r_be    <= n_be;
        r_res   <= n_res;
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

endmodule
